FILE: hw/rtl/peer_table_stale_prune_core_defines.svh
// ----------------------------------------------------------------------------
// Peer table assertion macros
// Shared concurrent assertion forms used by the peer table RTL.
// ----------------------------------------------------------------------------
`ifndef PEER_TABLE_STALE_PRUNE_CORE_DEFINES_SVH
`define PEER_TABLE_STALE_PRUNE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTSP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/ptsp_pkg.sv
// ----------------------------------------------------------------------------
// Peer table package
// Entry layout, compare status and result codes shared by the peer table RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptsp_pkg;

   localparam int ADDR_W = 48;
   localparam int TYPE_W = 8;
   localparam int RSSI_W = 8;
   localparam int TIME_W = 32;
   localparam int OUTCOME_W = 2;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 8;

   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd60000;

   localparam logic [OUTCOME_W-1:0] OUTCOME_REFRESHED = 2'd0;
   localparam logic [OUTCOME_W-1:0] OUTCOME_INSERTED  = 2'd1;
   localparam logic [OUTCOME_W-1:0] OUTCOME_DROPPED   = 2'd2;

   // One stored peer, also the form of an incoming sighting.
   typedef struct packed {
      logic [TIME_W-1:0] last_seen;
      logic [RSSI_W-1:0] rssi;
      logic [TYPE_W-1:0] addr_type;
      logic [ADDR_W-1:0] addr_value;
   } entry_type;

   // Result of comparing one stored entry against the sighting.
   typedef struct packed {
      logic match;
      logic stale;
   } cmp_status_type;

endpackage

FILE: hw/rtl/ptsp_entry_cmp.sv
// ----------------------------------------------------------------------------
// Peer entry compare unit
// Checks one stored entry for an address match and for staleness.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptsp_entry_cmp
   import ptsp_pkg::*;
(
   input  entry_type          entry,
   input  entry_type          sighting,
   input  logic [TIME_W-1:0]  timeout_ms,
   output cmp_status_type     status
);

   logic [TIME_W-1:0] age;

   // Age wraps at 32 bits, so a last-seen time ahead of now looks very old.
   assign age = sighting.last_seen - entry.last_seen;

   assign status.match = (entry.addr_value == sighting.addr_value) &&
                         (entry.addr_type == sighting.addr_type);
   assign status.stale = (age >= timeout_ms);

endmodule

FILE: hw/rtl/peer_table_stale_prune_core.sv
// ----------------------------------------------------------------------------
// Peer table with stale pruning
// Keeps up to MAX_PEERS radio peers, refreshing known ones and appending new
// ones, and prunes stale entries when the table is full.
// ----------------------------------------------------------------------------
// A sighting word is taken when the core is idle and answered with one result
// word. The core searches the table one entry at a time, a read step then a
// compare step, because the entries sit in a memory with one registered read
// port and one compare unit serves every step. A match refreshes that entry,
// a miss appends the sighting if the table has room, and a sighting that
// meets a full table adds a pruning pass over every entry before it is
// inserted or dropped. The next sighting may be taken while the previous result
// word still waits on the result side.
`timescale 1ns / 1ps

`include "peer_table_stale_prune_core_defines.svh"

module peer_table_stale_prune_core
   import ptsp_pkg::*;
#(
   parameter int MAX_PEERS = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   // Sighting words.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // From bit 0: addr_value[47:0], addr_type[55:48], rssi[63:56], now_ms[95:64].
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // Result words.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // From bit 0: outcome[1:0], zero fill above.
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // Timeout register write.
   input  logic                   csr_wr_en,
   input  logic [TIME_W-1:0]      csr_wr_data
);

   localparam int IDX_W = (MAX_PEERS > 1) ? $clog2(MAX_PEERS) : 1;
   localparam int CNT_W = $clog2(MAX_PEERS + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_PEERS);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SCAN_RD  = 3'd1;
   localparam logic [2:0] ST_SCAN_CHK = 3'd2;
   localparam logic [2:0] ST_DECIDE   = 3'd3;
   localparam logic [2:0] ST_PR_RD    = 3'd4;
   localparam logic [2:0] ST_PR_CHK   = 3'd5;
   localparam logic [2:0] ST_DONE     = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [TIME_W-1:0]     timeout_ff;
   entry_type             sighting_ff, sighting_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      keep_ff, keep_in;
   logic                  pruned_ff, pruned_in;
   logic [OUTCOME_W-1:0]  outcome_ff, outcome_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUTCOME_W-1:0]  rsp_outcome_ff, rsp_outcome_in;

   entry_type             entry_mem [MAX_PEERS];
   entry_type             rd_data_ff;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   entry_type             wr_data;

   cmp_status_type        cmp_status;
   logic                  req_fire;
   logic                  last_idx;
   logic                  rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - OUTCOME_W){1'b0}}, rsp_outcome_ff};
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign last_idx   = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);

   // Timeout register.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_wr_en) begin
         timeout_ff <= csr_wr_data;
      end
   end

   // Shared compare unit over the entry just read.
   ptsp_entry_cmp u_cmp (
      .entry      (rd_data_ff),
      .sighting   (sighting_ff),
      .timeout_ms (timeout_ff),
      .status     (cmp_status)
   );

   // Entry memory: one write port, one registered read port at the scan index.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[idx_ff];
   end

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      sighting_in    = sighting_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      keep_in        = keep_ff;
      pruned_in      = pruned_ff;
      outcome_in     = outcome_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_outcome_in = rsp_outcome_ff;
      wr_en          = 1'b0;
      wr_addr        = idx_ff;
      wr_data        = sighting_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               sighting_in.addr_value = req_tdata[47:0];
               sighting_in.addr_type  = req_tdata[55:48];
               sighting_in.rssi       = req_tdata[63:56];
               sighting_in.last_seen  = req_tdata[95:64];
               idx_in    = '0;
               pruned_in = 1'b0;
               state_in  = (count_ff == '0) ? ST_DECIDE : ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (cmp_status.match) begin
               // Same address and type: rewrite the entry with the new
               // strength and time.
               wr_en      = 1'b1;
               wr_addr    = idx_ff;
               outcome_in = OUTCOME_REFRESHED;
               state_in   = ST_DONE;
            end else if (last_idx) begin
               state_in = ST_DECIDE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_DECIDE: begin
            if (count_ff < FULL_COUNT) begin
               wr_en      = 1'b1;
               wr_addr    = count_ff[IDX_W-1:0];
               count_in   = count_ff + CNT_W'(1);
               outcome_in = OUTCOME_INSERTED;
               state_in   = ST_DONE;
            end else if (pruned_ff) begin
               outcome_in = OUTCOME_DROPPED;
               state_in   = ST_DONE;
            end else begin
               idx_in   = '0;
               keep_in  = '0;
               state_in = ST_PR_RD;
            end
         end
         ST_PR_RD: begin
            state_in = ST_PR_CHK;
         end
         ST_PR_CHK: begin
            // Survivors slide down to the keep position in their order.
            if (!cmp_status.stale) begin
               wr_en   = (keep_ff != CNT_W'(idx_ff));
               wr_addr = keep_ff[IDX_W-1:0];
               wr_data = rd_data_ff;
               keep_in = keep_ff + CNT_W'(1);
            end
            if (last_idx) begin
               count_in  = keep_in;
               pruned_in = 1'b1;
               state_in  = ST_DECIDE;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_PR_RD;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_outcome_in = outcome_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         keep_ff      <= '0;
         pruned_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         keep_ff      <= keep_in;
         pruned_ff    <= pruned_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      sighting_ff    <= sighting_in;
      outcome_ff     <= outcome_in;
      rsp_outcome_ff <= rsp_outcome_in;
   end

   // Checks on the sequencer and table bookkeeping.
   `PTSP_ASSERT_SAME(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_COUNT,
      "entry count exceeds table depth")
   `PTSP_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_tready,
      "core ready again right after taking a sighting")
   `PTSP_ASSERT_SAME(a_keep_behind_scan, clock, reset, state_ff == ST_PR_CHK,
      keep_ff <= CNT_W'(idx_ff), "prune keep pointer ran ahead of the scan")
   `PTSP_ASSERT_SAME(a_outcome_code, clock, reset, rsp_valid_ff,
      rsp_outcome_ff <= OUTCOME_DROPPED, "result word carries an unused outcome code")
   `PTSP_ASSERT_SAME(a_prune_only_full, clock, reset, state_ff == ST_PR_RD,
      count_ff == FULL_COUNT, "pruning pass started on a table that is not full")

endmodule
